@@ src/td0v_pkg.sv @@
`timescale 1ns / 1ps

package td0v_pkg;

	localparam int PHI_BITS_DEF = 16;

	// pi in Q30, used to turn a 2^-32 turn angle into Q30 radians
	localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;

	localparam int TAY_STEPS = 6;
	localparam int SC_LAT    = 3 + 3 * TAY_STEPS + 1;
	localparam int POST_LAT  = 8;
	localparam int SQ_LAT    = 31;

	// sine series: divide by n*(n+1) for n = 2, 4, ... 12
	function automatic logic [31:0] sin_div(int k);
		case (k)
			0: return 32'd6;
			1: return 32'd20;
			2: return 32'd42;
			3: return 32'd72;
			4: return 32'd110;
			5: return 32'd156;
			default: return 32'd1;
		endcase
	endfunction

	// cosine series: divide by n*(n+1) for n = 1, 3, ... 11
	function automatic logic [31:0] cos_div(int k);
		case (k)
			0: return 32'd2;
			1: return 32'd12;
			2: return 32'd30;
			3: return 32'd56;
			4: return 32'd90;
			5: return 32'd132;
			default: return 32'd1;
		endcase
	endfunction

endpackage

@@ src/td0v_trk_if.sv @@
`timescale 1ns / 1ps

interface td0v_trk_if #(parameter int PHI_BITS = td0v_pkg::PHI_BITS_DEF);
	logic                valid;
	logic                ready;
	logic signed [31:0]  track_d0;
	logic [PHI_BITS-1:0] track_phi;
	logic [30:0]         track_d0_error;
	logic [30:0]         track_phi_error;
	logic signed [47:0]  cov_d0_phi;
	logic signed [31:0]  vertex_x;
	logic signed [31:0]  vertex_y;
	logic [46:0]         vertex_var_xx;
	logic signed [47:0]  vertex_cov_xy;
	logic [46:0]         vertex_var_yy;

	modport source (output valid, track_d0, track_phi, track_d0_error, track_phi_error,
		cov_d0_phi, vertex_x, vertex_y, vertex_var_xx, vertex_cov_xy, vertex_var_yy,
		input ready);
	modport sink (input valid, track_d0, track_phi, track_d0_error, track_phi_error,
		cov_d0_phi, vertex_x, vertex_y, vertex_var_xx, vertex_cov_xy, vertex_var_yy,
		output ready);
endinterface

@@ src/td0v_res_if.sv @@
`timescale 1ns / 1ps

interface td0v_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] d0_at_vertex;
	logic signed [31:0] d0_error_at_vertex;
	logic               negative_variance;

	modport source (output valid, d0_at_vertex, d0_error_at_vertex, negative_variance,
		input ready);
	modport sink (input valid, d0_at_vertex, d0_error_at_vertex, negative_variance,
		output ready);
endinterface

@@ src/track_d0_to_vertex.sv @@
`timescale 1ns / 1ps
// Throughput: one request per cycle; the pipeline only halts when the two-entry output
// queue is full, and the queue is what holds a result while the sink stalls.
// Depth is set by the 18-stage sine/cosine series and the 31-stage square root.
// Reset clears the valid bits and the output queue; data registers are not reset.

module track_d0_to_vertex #(
	parameter int PHI_BITS = td0v_pkg::PHI_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	td0v_trk_if.sink  trk,
	td0v_res_if.source res
);

	localparam int SC  = td0v_pkg::SC_LAT;
	localparam int SQ  = td0v_pkg::SQ_LAT;
	localparam int TOT = SC + td0v_pkg::POST_LAT + SQ;

	typedef struct packed {
		logic signed [31:0] d0;
		logic [30:0]        d0e;
		logic [30:0]        phe;
		logic signed [47:0] cdp;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [46:0]        vxx;
		logic signed [47:0] vxy;
		logic [46:0]        vyy;
	} fld_t;

	typedef struct packed {
		logic signed [31:0] dv;
		logic               neg;
		logic               sat;
	} side_t;

	typedef struct packed {
		logic signed [31:0] d0v;
		logic signed [31:0] err;
		logic               neg;
	} res_t;

	// Global advance: the whole pipeline moves while the output queue has room.
	logic           en;
	logic [TOT-1:0] vld_q;
	logic [1:0]     cnt_q;
	logic           wr_q;
	logic           rd_q;
	res_t           ent_q [2];

	assign en        = cnt_q != 2'd2;
	assign trk.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], trk.valid};
		end
	end

	// ---------------------------------------------------------------
	// Sine and cosine of phi; carry the other fields alongside.
	// ---------------------------------------------------------------
	logic signed [31:0] sine;
	logic signed [31:0] cosine;
	fld_t               fld_in;
	fld_t               fld_s [SC];

	td0v_sincos #(.PHI_BITS(PHI_BITS)) u_sincos (
		.clk    (clk),
		.en     (en),
		.phi    (trk.track_phi),
		.sine   (sine),
		.cosine (cosine)
	);

	always_comb begin
		fld_in.d0  = trk.track_d0;
		fld_in.d0e = trk.track_d0_error;
		fld_in.phe = trk.track_phi_error;
		fld_in.cdp = trk.cov_d0_phi;
		fld_in.bx  = trk.vertex_x;
		fld_in.by  = trk.vertex_y;
		fld_in.vxx = trk.vertex_var_xx;
		fld_in.vxy = trk.vertex_cov_xy;
		fld_in.vyy = trk.vertex_var_yy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fld_s[0] <= fld_in;
			for (int i = 1; i < SC; i++) begin
				fld_s[i] <= fld_s[i-1];
			end
		end
	end

	fld_t fd;
	assign fd = fld_s[SC-1];

	// ---------------------------------------------------------------
	// Stage 23: rotation products and trig squares.
	// ---------------------------------------------------------------
	logic signed [63:0] byc_s23, bxs_s23, bxc_s23, bys_s23, ss_s23, cc_s23, scp_s23;
	logic [61:0]        d0sq_s23;
	logic signed [31:0] d0_s23;
	logic [30:0]        phe_s23;
	logic signed [47:0] cdp_s23;
	logic [46:0]        vxx_s23, vyy_s23;
	logic signed [47:0] vxy_s23;

	always_ff @(posedge clk) begin
		if (en) begin
			byc_s23  <= fd.by * cosine;
			bxs_s23  <= fd.bx * sine;
			bxc_s23  <= fd.bx * cosine;
			bys_s23  <= fd.by * sine;
			ss_s23   <= sine * sine;
			cc_s23   <= cosine * cosine;
			scp_s23  <= sine * cosine;
			d0sq_s23 <= fd.d0e * fd.d0e;
			d0_s23   <= fd.d0;
			phe_s23  <= fd.phe;
			cdp_s23  <= fd.cdp;
			vxx_s23  <= fd.vxx;
			vxy_s23  <= fd.vxy;
			vyy_s23  <= fd.vyy;
		end
	end

	// ---------------------------------------------------------------
	// Stage 24: round everything back to Q24 / Q30 (half up).
	// ---------------------------------------------------------------
	logic signed [63:0] dsum, lsum, sss, ccs, scs;
	logic signed [33:0] corr_s24, l24_s24;
	logic [30:0]        s2_s24, c2_s24;
	logic signed [31:0] sc_s24;
	logic [61:0]        d0sq_s24;
	logic signed [31:0] d0_s24;
	logic [30:0]        phe_s24;
	logic signed [47:0] cdp_s24;
	logic [46:0]        vxx_s24, vyy_s24;
	logic signed [47:0] vxy_s24;

	always_comb begin
		dsum = byc_s23 - bxs_s23 + 64'sd536870912;
		lsum = bxc_s23 + bys_s23 + 64'sd536870912;
		sss  = ss_s23 + 64'sd536870912;
		ccs  = cc_s23 + 64'sd536870912;
		scs  = scp_s23 + 64'sd536870912;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corr_s24 <= 34'(dsum >>> 30);
			l24_s24  <= 34'(lsum >>> 30);
			s2_s24   <= 31'(sss >>> 30);
			c2_s24   <= 31'(ccs >>> 30);
			sc_s24   <= 32'(scs >>> 30);
			d0sq_s24 <= d0sq_s23;
			d0_s24   <= d0_s23;
			phe_s24  <= phe_s23;
			cdp_s24  <= cdp_s23;
			vxx_s24  <= vxx_s23;
			vxy_s24  <= vxy_s23;
			vyy_s24  <= vyy_s23;
		end
	end

	// ---------------------------------------------------------------
	// Stage 25: saturate d0, form L*phierr and split the wide covariance products.
	// ---------------------------------------------------------------
	logic signed [34:0] dsat;
	logic signed [31:0] dv_n;
	logic [32:0]        lm;
	logic signed [31:0] dv_s25;
	logic [63:0]        p48_s25;
	logic signed [58:0] pl_lo_s25;
	logic signed [57:0] pl_hi_s25;
	logic [54:0]        pxx_lo_s25, pyy_lo_s25;
	logic [53:0]        pxx_hi_s25, pyy_hi_s25;
	logic signed [56:0] pxy_lo_s25;
	logic signed [55:0] pxy_hi_s25;
	logic [61:0]        d0sq_s25;

	always_comb begin
		dsat = 35'(d0_s24) + 35'(corr_s24);
		if (dsat > 35'sd2147483647) begin
			dv_n = 32'sh7FFF_FFFF;
		end else if (dsat < -35'sd2147483648) begin
			dv_n = 32'sh8000_0000;
		end else begin
			dv_n = dsat[31:0];
		end
		lm = l24_s24[33] ? 33'(-l24_s24) : 33'(l24_s24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s25     <= dv_n;
			p48_s25    <= lm * phe_s24;
			pl_lo_s25  <= l24_s24 * $signed({1'b0, cdp_s24[23:0]});
			pl_hi_s25  <= l24_s24 * $signed(cdp_s24[47:24]);
			pxx_lo_s25 <= s2_s24 * vxx_s24[23:0];
			pxx_hi_s25 <= s2_s24 * vxx_s24[46:24];
			pyy_lo_s25 <= c2_s24 * vyy_s24[23:0];
			pyy_hi_s25 <= c2_s24 * vyy_s24[46:24];
			pxy_lo_s25 <= sc_s24 * $signed({1'b0, vxy_s24[23:0]});
			pxy_hi_s25 <= sc_s24 * $signed(vxy_s24[47:24]);
			d0sq_s25   <= d0sq_s24;
		end
	end

	// ---------------------------------------------------------------
	// Stage 26: rejoin the partial products, round L*phierr to Q39.
	// ---------------------------------------------------------------
	logic [55:0]        p39_s26;
	logic signed [81:0] lcd_s26;
	logic [77:0]        xx_s26, yy_s26;
	logic signed [79:0] xy_s26;
	logic [61:0]        d0sq_s26;
	logic signed [31:0] dv_s26;

	always_ff @(posedge clk) begin
		if (en) begin
			p39_s26  <= 56'(p48_s25 >> 9) + 56'(p48_s25[8]);
			lcd_s26  <= (82'(pl_hi_s25) <<< 24) + 82'(pl_lo_s25);
			xx_s26   <= (78'(pxx_hi_s25) << 24) + 78'(pxx_lo_s25);
			yy_s26   <= (78'(pyy_hi_s25) << 24) + 78'(pyy_lo_s25);
			xy_s26   <= (80'(pxy_hi_s25) <<< 24) + 80'(pxy_lo_s25);
			d0sq_s26 <= d0sq_s25;
			dv_s26   <= dv_s25;
		end
	end

	// ---------------------------------------------------------------
	// Stage 27: square L*phierr in halves; first partial sums at 2^-78.
	// ---------------------------------------------------------------
	logic [55:0]        ll_s27, lh_s27, hh_s27;
	logic [127:0]       a_s27, b_s27;
	logic signed [31:0] dv_s27;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s27 <= p39_s26[27:0] * p39_s26[27:0];
			lh_s27 <= p39_s26[27:0] * p39_s26[55:28];
			hh_s27 <= p39_s26[55:28] * p39_s26[55:28];
			a_s27  <= (128'(d0sq_s26) << 30) - (128'(lcd_s26) << 7);
			b_s27  <= 128'(xx_s26) + 128'(yy_s26) - (128'(xy_s26) << 1);
			dv_s27 <= dv_s26;
		end
	end

	// Stage 28
	logic [127:0]       pp_s28, ab_s28;
	logic signed [31:0] dv_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s28 <= (128'(hh_s27) << 56) + (128'(lh_s27) << 29) + 128'(ll_s27);
			ab_s28 <= a_s27 + b_s27;
			dv_s28 <= dv_s27;
		end
	end

	// Stage 29: full variance
	logic [127:0]       sum_s29;
	logic signed [31:0] dv_s29;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s29 <= ab_s28 + pp_s28;
			dv_s29  <= dv_s28;
		end
	end

	// ---------------------------------------------------------------
	// Stage 30: magnitude rounded to 2^-48, overflow check.
	// ---------------------------------------------------------------
	logic               neg_n;
	logic [127:0]       mag;
	logic [61:0]        q_s30;
	side_t              side_n;
	// one entry more than the root stages: side_s[0] is registered with q_s30, ahead of the root stages
	side_t              side_s [SQ+1];

	always_comb begin
		neg_n      = sum_s29[127];
		mag        = (neg_n ? ~sum_s29 : sum_s29)
		           + (neg_n ? 128'h2000_0001 : 128'h2000_0000);
		side_n.dv  = dv_s29;
		side_n.neg = neg_n;
		side_n.sat = |mag[127:92];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s30     <= mag[91:30];
			side_s[0] <= side_n;
			for (int i = 1; i <= SQ; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Square root, one bit per stage; side data follows in side_s.
	// ---------------------------------------------------------------
	logic [SQ-1:0] root;

	td0v_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (q_s30),
		.root     (root)
	);

	res_t  fin;
	side_t sd;

	assign sd = side_s[SQ];

	always_comb begin
		fin.d0v = sd.dv;
		fin.neg = sd.neg;
		if (sd.sat) begin
			fin.err = sd.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			fin.err = sd.neg ? -32'(root) : 32'(root);
		end
	end

	// ---------------------------------------------------------------
	// Output queue: two entries, so the tail can drain while the sink stalls.
	// ---------------------------------------------------------------
	logic push;
	logic pop;

	assign push = en & vld_q[TOT-1];
	assign pop  = res.valid & res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= fin;
		end
	end

	assign res.valid              = cnt_q != 2'd0;
	assign res.d0_at_vertex       = ent_q[rd_q].d0v;
	assign res.d0_error_at_vertex = ent_q[rd_q].err;
	assign res.negative_variance  = ent_q[rd_q].neg;

endmodule

@@ src/td0v_sincos.sv @@
`timescale 1ns / 1ps

module td0v_sincos #(
	parameter int PHI_BITS = td0v_pkg::PHI_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [PHI_BITS-1:0] phi,
	output logic signed [31:0]  sine,
	output logic signed [31:0]  cosine
);

	localparam int STG = 3 * td0v_pkg::TAY_STEPS;

	typedef struct packed {
		logic [29:0]        x2;
		logic [30:0]        ts;
		logic [30:0]        tc;
		logic [30:0]        ps;
		logic [30:0]        pc;
		logic signed [31:0] s;
		logic signed [31:0] c;
		logic [1:0]         quad;
		logic               swap;
	} tay_t;

	logic [31:0] ang;
	logic [29:0] rin;
	logic        swap_n;
	logic [29:0] rf_n;
	logic [29:0] rf_s1;
	logic [1:0]  quad_s1, quad_s2;
	logic        swap_s1, swap_s2;
	logic [61:0] ap;
	logic [29:0] x_s2;
	logic [60:0] xx;
	tay_t        init;
	tay_t        tay_s [STG+1];
	tay_t        fin;

	// fold the angle into the first octant of its quadrant
	always_comb begin
		ang    = {phi, {(32-PHI_BITS){1'b0}}};
		rin    = ang[29:0];
		swap_n = rin > 30'h2000_0000;
		rf_n   = swap_n ? 30'(31'h4000_0000 - {1'b0, rin}) : rin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rf_s1   <= rf_n;
			quad_s1 <= ang[31:30];
			swap_s1 <= swap_n;
		end
	end

	assign ap = 62'(rf_s1) * 62'(td0v_pkg::PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= 30'((ap + 62'h4000_0000) >> 31);
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
		end
	end

	always_comb begin
		xx        = 61'(x_s2) * 61'(x_s2);
		init.x2   = 30'((xx + 61'h2000_0000) >> 30);
		init.ts   = {1'b0, x_s2};
		init.tc   = 31'h4000_0000;
		init.ps   = '0;
		init.pc   = '0;
		init.s    = 32'($signed({2'b00, x_s2}));
		init.c    = 32'sh4000_0000;
		init.quad = quad_s2;
		init.swap = swap_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tay_s[0] <= init;
		end
	end

	// each series term: multiply by x^2, divide by a constant, then fix up and accumulate
	for (genvar j = 0; j < STG; j++) begin : g_tay
		localparam int K    = j / 3;
		localparam int KIND = j % 3;
		localparam logic [31:0] DSV = td0v_pkg::sin_div(K);
		localparam logic [31:0] DCV = td0v_pkg::cos_div(K);
		localparam logic [30:0] MSV = 31'((64'd1 << 31) / DSV);
		localparam logic [30:0] MCV = 31'((64'd1 << 31) / DCV);

		tay_t        nxt;
		logic [61:0] prs;
		logic [61:0] prc;
		logic [31:0] rs;
		logic [31:0] rc;
		logic [30:0] qs;
		logic [30:0] qc;

		always_comb begin
			nxt = tay_s[j];
			prs = '0;
			prc = '0;
			rs  = '0;
			rc  = '0;
			qs  = '0;
			qc  = '0;
			if (KIND == 0) begin
				prs    = tay_s[j].ts * tay_s[j].x2;
				prc    = tay_s[j].tc * tay_s[j].x2;
				nxt.ps = 31'(prs >> 30);
				nxt.pc = 31'(prc >> 30);
			end else if (KIND == 1) begin
				prs    = tay_s[j].ps * MSV;
				prc    = tay_s[j].pc * MCV;
				nxt.ts = 31'(prs >> 31);
				nxt.tc = 31'(prc >> 31);
			end else begin
				rs     = 32'(tay_s[j].ps) - 32'(tay_s[j].ts) * DSV;
				rc     = 32'(tay_s[j].pc) - 32'(tay_s[j].tc) * DCV;
				qs     = (rs >= DSV) ? tay_s[j].ts + 31'd1 : tay_s[j].ts;
				qc     = (rc >= DCV) ? tay_s[j].tc + 31'd1 : tay_s[j].tc;
				nxt.ts = qs;
				nxt.tc = qc;
				nxt.s  = (K % 2 == 0) ? tay_s[j].s - 32'(qs) : tay_s[j].s + 32'(qs);
				nxt.c  = (K % 2 == 0) ? tay_s[j].c - 32'(qc) : tay_s[j].c + 32'(qc);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tay_s[j+1] <= nxt;
			end
		end
	end

	// unfold: swap back, then rotate by the quadrant
	logic signed [31:0] so;
	logic signed [31:0] co;
	logic signed [31:0] sq;
	logic signed [31:0] cq;

	always_comb begin
		fin = tay_s[STG];
		so  = fin.swap ? fin.c : fin.s;
		co  = fin.swap ? fin.s : fin.c;
		sq  = fin.quad[0] ? co : so;
		cq  = fin.quad[0] ? -so : co;
		if (fin.quad[1]) begin
			sq = -sq;
			cq = -cq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine   <= sq;
			cosine <= cq;
		end
	end

endmodule

@@ src/td0v_isqrt.sv @@
`timescale 1ns / 1ps

module td0v_isqrt (
	input  logic                              clk,
	input  logic                              en,
	input  logic [2*td0v_pkg::SQ_LAT-1:0]     radicand,
	output logic [td0v_pkg::SQ_LAT-1:0]       root
);

	localparam int N  = td0v_pkg::SQ_LAT;
	localparam int RW = 2 * N;

	logic [RW-1:0] rem_s [N];
	logic [RW:0]   res_s [N];

	// one result bit per stage, most significant first; the radicand is below 2^62
	for (genvar i = 0; i < N; i++) begin : g_bit
		localparam logic [RW:0] BIT = (RW+1)'(1) << (RW - 2 - 2 * i);

		logic [RW-1:0] rem_p;
		logic [RW:0]   res_p;
		logic [RW+1:0] trial;
		logic [RW-1:0] rem_n;
		logic [RW:0]   res_n;

		if (i == 0) begin : g_first
			assign rem_p = radicand;
			assign res_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign res_p = res_s[i-1];
		end

		always_comb begin
			trial = {1'b0, res_p} + {1'b0, BIT};
			if ({2'b00, rem_p} >= trial) begin
				rem_n = RW'({2'b00, rem_p} - trial);
				res_n = (res_p >> 1) + BIT;
			end else begin
				rem_n = rem_p;
				res_n = res_p >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= rem_n;
				res_s[i] <= res_n;
			end
		end
	end

	assign root = res_s[N-1][N-1:0];

endmodule
